@@ src/acd_pkg.sv @@
package acd_pkg;

	// Source clock and quotient width
	localparam int SRC_W = 30;
	// Bit clock target: 19-bit rate, x2 stereo, x64 width factor
	localparam int TGT_W = 26;
	localparam int BITS_W = 6;
	localparam int RATE_W = 19;
	localparam int PRE_OUT_W = 3;
	localparam int DIV_OUT_W = 6;

	localparam logic [SRC_W-1:0] SRC_CLK_RESET = 30'd786480000;

	// Target bit clock: rate, doubled for stereo, then x16/x32/x64 by width class.
	// Widths above 32 get no width factor.
	function automatic logic [TGT_W-1:0] target_clock(
		input logic [BITS_W-1:0] bits,
		input logic [RATE_W-1:0] rate,
		input logic              stereo
	);
		logic [TGT_W-1:0] t;
		t = TGT_W'(rate);
		if (stereo) begin
			t = t << 1;
		end
		if (bits <= BITS_W'(8)) begin
			t = t << 4;
		end else if (bits <= BITS_W'(16)) begin
			t = t << 5;
		end else if (bits <= BITS_W'(32)) begin
			t = t << 6;
		end
		return t;
	endfunction

endpackage

@@ src/acd_div.sv @@
module acd_div import acd_pkg::*; #(
	parameter int DEN_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SRC_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [SRC_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SRC_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;
	logic [SRC_W-1:0] quo_q;

	// restoring step: shift in next dividend bit, subtract if it fits
	logic [DEN_W:0] trial;
	logic           fits;

	assign trial = {rem_q, quo_q[SRC_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SRC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, div_q}) : DEN_W'(trial);
			quo_q <= {quo_q[SRC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/audio_clock_divider_search.sv @@
// Audio bit-clock divider search. Each input beat (sample_bits, sample_rate,
// is_stereo) asks for the pre-divider and main divider settings that bring
// the source clock (cfg register, reset 786480000 Hz) closest to the bit
// clock rate x (2 if stereo) x 16/32/64. Candidates run pre-divider outermost,
// then main divider, then bit divider 1..BIT_DIV_MAX; the candidate clock is
// source / (2 * bitdiv * (main+1) * (pre+1)), which equals the chained floor
// divisions. An exact hit stops the search; otherwise the first candidate with
// strictly smallest error below the target wins, and 0/0 comes back when none
// does. Timing: one shared restoring divider, one quotient bit per cycle;
// each candidate starts it in S_START and waits for its done in S_WAIT, and
// an exact hit cuts the search short. The block takes one beat at a time:
// in_stall stays high from acceptance until the result beat is taken.
// Write cfg only while idle; the result holds on out_stall.
module audio_clock_divider_search import acd_pkg::*; #(
	parameter int PRE_DIV_MAX = 7,
	parameter int DIV_MAX     = 63,
	parameter int BIT_DIV_MAX = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [SRC_W-1:0]     cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BITS_W-1:0]    sample_bits,
	input  logic [RATE_W-1:0]    sample_rate,
	input  logic                 is_stereo,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PRE_OUT_W-1:0] pre_divider,
	output logic [DIV_OUT_W-1:0] main_divider,
	output logic                 exact_hit
);

	localparam int PRE_W = $clog2(PRE_DIV_MAX + 1);
	localparam int DV_W  = $clog2(DIV_MAX + 1);
	localparam int BD_W  = $clog2(BIT_DIV_MAX + 1);
	// (pre+1)*(main+1) and the full divisor 2*bd*(pre+1)*(main+1)
	localparam int PD_W  = $clog2((PRE_DIV_MAX + 1) * (DIV_MAX + 1) + 1);
	localparam int DEN_W = $clog2(2 * BIT_DIV_MAX * (PRE_DIV_MAX + 1) * (DIV_MAX + 1) + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [1:0]       state_q;
	logic [SRC_W-1:0] src_clk_q;

	// search counters; pd_q = (pre+1)*(main+1), den_q = 2*bd*pd_q, kept by adds
	logic [PRE_W-1:0] pre_q;
	logic [DV_W-1:0]  dv_q;
	logic [BD_W-1:0]  bd_q;
	logic [PD_W-1:0]  pd_q;
	logic [DEN_W-1:0] den_q;

	logic [TGT_W-1:0] target_q;
	logic [SRC_W-1:0] best_err_q;
	logic [PRE_W-1:0] best_pre_q;
	logic [DV_W-1:0]  best_dv_q;
	logic             exact_q;

	logic             div_start;
	logic             div_done;
	logic [SRC_W-1:0] cand;

	acd_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (src_clk_q),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (cand)
	);

	assign div_start = state_q == S_START;

	logic [SRC_W-1:0] tgt_ext;
	logic [SRC_W-1:0] err;
	logic             hit;
	logic [PD_W-1:0]  pd_dv_inc;
	logic [PD_W-1:0]  pd_pre_inc;

	assign tgt_ext    = SRC_W'(target_q);
	assign hit        = cand == tgt_ext;
	assign err        = (tgt_ext > cand) ? tgt_ext - cand : cand - tgt_ext;
	// next main divider: pd += pre+1; next pre-divider: pd = pre+2
	assign pd_dv_inc  = PD_W'(pd_q + PD_W'(pre_q) + PD_W'(1));
	assign pd_pre_inc = PD_W'(PD_W'(pre_q) + PD_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			src_clk_q <= SRC_CLK_RESET;
		end else begin
			if (cfg_wr_en) begin
				src_clk_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						if (hit) begin
							state_q <= S_OUT;
						end else if (bd_q != BD_W'(BIT_DIV_MAX) || dv_q != DV_W'(DIV_MAX)
								|| pre_q != PRE_W'(PRE_DIV_MAX)) begin
							state_q <= S_START;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			target_q   <= target_clock(sample_bits, sample_rate, is_stereo);
			best_err_q <= SRC_W'(target_clock(sample_bits, sample_rate, is_stereo));
			best_pre_q <= '0;
			best_dv_q  <= '0;
			exact_q    <= 1'b0;
			pre_q      <= '0;
			dv_q       <= '0;
			bd_q       <= BD_W'(1);
			pd_q       <= PD_W'(1);
			den_q      <= DEN_W'(2);
		end else if (state_q == S_WAIT && div_done) begin
			if (hit) begin
				best_pre_q <= pre_q;
				best_dv_q  <= dv_q;
				exact_q    <= 1'b1;
			end else if (err < best_err_q) begin
				best_err_q <= err;
				best_pre_q <= pre_q;
				best_dv_q  <= dv_q;
			end
			// step bit divider, then main divider, then pre-divider
			if (bd_q != BD_W'(BIT_DIV_MAX)) begin
				bd_q  <= bd_q + 1'b1;
				den_q <= DEN_W'(den_q + (DEN_W'(pd_q) << 1));
			end else if (dv_q != DV_W'(DIV_MAX)) begin
				dv_q  <= dv_q + 1'b1;
				bd_q  <= BD_W'(1);
				pd_q  <= pd_dv_inc;
				den_q <= DEN_W'(pd_dv_inc) << 1;
			end else if (pre_q != PRE_W'(PRE_DIV_MAX)) begin
				pre_q <= pre_q + 1'b1;
				dv_q  <= '0;
				bd_q  <= BD_W'(1);
				pd_q  <= pd_pre_inc;
				den_q <= DEN_W'(pd_pre_inc) << 1;
			end
		end
	end

	assign in_stall     = state_q != S_IDLE;
	assign out_valid    = state_q == S_OUT;
	assign pre_divider  = PRE_OUT_W'(best_pre_q);
	assign main_divider = DIV_OUT_W'(best_dv_q);
	assign exact_hit    = exact_q;

endmodule

@@ src/acd_chk.sv @@
module acd_chk import acd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [PRE_OUT_W-1:0] pre_divider,
	input logic [DIV_OUT_W-1:0] main_divider,
	input logic                 exact_hit
);

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pre_divider)
			&& $stable(main_divider) && $stable(exact_hit))
		else $error("result beat changed while stalled");

	// one beat in flight: accepted beat makes the input side busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again while search in flight");

	// a pending result blocks the input
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input ready while result pending");

	// search passes through S_START and S_WAIT: no result right after acceptance
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result appeared one cycle after accept");

endmodule

bind audio_clock_divider_search acd_chk u_acd_chk (.*);

@@ tb/sv/acd_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the divider search, predicts each result beat from
// the request beat and the current source clock, and compares in order.
module acd_result_checker import acd_pkg::*; #(
	parameter int PRE_DIV_MAX = 7,
	parameter int DIV_MAX     = 63,
	parameter int BIT_DIV_MAX = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [SRC_W-1:0]     cfg_wr_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [BITS_W-1:0]    sample_bits,
	input  logic [RATE_W-1:0]    sample_rate,
	input  logic                 is_stereo,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [PRE_OUT_W-1:0] pre_divider,
	input  logic [DIV_OUT_W-1:0] main_divider,
	input  logic                 exact_hit,
	output int                   mismatches,
	output int                   pending
);

	typedef struct packed {
		logic [PRE_OUT_W-1:0] pre;
		logic [DIV_OUT_W-1:0] main;
		logic                 hit;
	} divider_choice_t;

	divider_choice_t  expected_choices[$];
	logic [SRC_W-1:0] source_hz;

	// Walks pre, main, bit divider in order; first strictly better error wins,
	// an exact hit stops the walk.
	function automatic divider_choice_t search_dividers(
		input logic [SRC_W-1:0]  src,
		input logic [BITS_W-1:0] bits,
		input logic [RATE_W-1:0] rate,
		input logic              stereo
	);
		longint unsigned bit_clk, best_err, err, master, cand;
		int              pre_i, div_i, bd_i;
		bit              hit_found;
		divider_choice_t pick;
		bit_clk = 64'(rate);
		if (stereo) begin
			bit_clk = bit_clk * 2;
		end
		if (bits <= 8) begin
			bit_clk = bit_clk * 16;
		end else if (bits <= 16) begin
			bit_clk = bit_clk * 32;
		end else if (bits <= 32) begin
			bit_clk = bit_clk * 64;
		end
		best_err  = bit_clk;
		hit_found = 1'b0;
		pick      = '0;
		for (pre_i = 0; pre_i <= PRE_DIV_MAX && !hit_found; pre_i++) begin
			for (div_i = 0; div_i <= DIV_MAX && !hit_found; div_i++) begin
				master = 64'(src) / 64'(div_i + 1) / 64'(pre_i + 1);
				for (bd_i = 1; bd_i <= BIT_DIV_MAX && !hit_found; bd_i++) begin
					cand = master / 2 / 64'(bd_i);
					if (cand == bit_clk) begin
						hit_found = 1'b1;
						pick.pre  = PRE_OUT_W'(pre_i);
						pick.main = DIV_OUT_W'(div_i);
					end else begin
						err = (bit_clk > cand) ? bit_clk - cand : cand - bit_clk;
						if (err < best_err) begin
							best_err  = err;
							pick.pre  = PRE_OUT_W'(pre_i);
							pick.main = DIV_OUT_W'(div_i);
						end
					end
				end
			end
		end
		pick.hit = hit_found;
		return pick;
	endfunction

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		divider_choice_t want;
		if (!arst_n) begin
			source_hz <= SRC_CLK_RESET;
		end else begin
			if (cfg_wr_en) begin
				source_hz <= cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				expected_choices.push_back(
					search_dividers(source_hz, sample_bits, sample_rate, is_stereo));
			end
			if (out_valid && !out_stall) begin
				if (expected_choices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%t: result beat with no request outstanding", $realtime);
					end
				end else begin
					want = expected_choices.pop_front();
					if (want.pre !== pre_divider || want.main !== main_divider
							|| want.hit !== exact_hit) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%t: expected pre %0d main %0d hit %0d, got pre %0d main %0d hit %0d",
								$realtime, want.pre, want.main, want.hit,
								pre_divider, main_divider, exact_hit);
						end
					end
				end
			end
			pending = expected_choices.size();
		end
	end

endmodule

@@ tb/sv/tb_audio_clock_divider_search.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the divider search. The checker beside the block
// does all prediction; this module only shapes request beats, retunes the
// source clock between phases, throttles the result side and judges the run.
//
// A search that finds no exact hit walks every candidate, so most random beats
// are built to land exactly on a shallow candidate of the current source clock.
// Only a few full walks are spent: the directed non-exact cases plus a small
// budget of pure noise.
module tb_audio_clock_divider_search;
	import acd_pkg::*;

	localparam int PRE_MAX  = 7;
	localparam int MAIN_MAX = 63;
	localparam int BIT_MAX  = 7;
	// One full walk over every candidate, taken four times over.
	localparam int QUIET_LIMIT = 4 * (32 * (PRE_MAX + 1) * (MAIN_MAX + 1) * BIT_MAX + 64);

	// Width classes of the bit clock multiplier: x16, x32, x64, none.
	typedef enum int {UP_TO_8, UP_TO_16, UP_TO_32, OVER_32} width_class_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_wr_en    = 1'b0;
	logic [SRC_W-1:0]     cfg_wr_data  = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [BITS_W-1:0]    sample_bits  = '0;
	logic [RATE_W-1:0]    sample_rate  = '0;
	logic                 is_stereo    = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [PRE_OUT_W-1:0] pre_divider;
	logic [DIV_OUT_W-1:0] main_divider;
	logic                 exact_hit;

	int mismatches;
	int pending;
	int n_requests = 0;
	int n_results  = 0;
	int n_exact    = 0;
	int n_settings = 1;
	int noise_left = 3;   // full walks that random noise may still cost
	int stall_left = 0;
	int quiet      = 0;
	bit idle_on    = 1'b1;

	always #10 clk = ~clk;

	audio_clock_divider_search #(
		.PRE_DIV_MAX(PRE_MAX),
		.DIV_MAX    (MAIN_MAX),
		.BIT_DIV_MAX(BIT_MAX)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_bits (sample_bits),
		.sample_rate (sample_rate),
		.is_stereo   (is_stereo),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pre_divider (pre_divider),
		.main_divider(main_divider),
		.exact_hit   (exact_hit)
	);

	acd_result_checker #(
		.PRE_DIV_MAX(PRE_MAX),
		.DIV_MAX    (MAIN_MAX),
		.BIT_DIV_MAX(BIT_MAX)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_bits (sample_bits),
		.sample_rate (sample_rate),
		.is_stereo   (is_stereo),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pre_divider (pre_divider),
		.main_divider(main_divider),
		.exact_hit   (exact_hit),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	// Result side throttle: random bursts of stalled cycles, changed on the
	// falling edge. The result holds while stalled, so bursts that start
	// mid-result land on every cycle of its wait.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Beat counters and the watchdog on cycles where neither channel moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
			if (in_valid && !in_stall) begin
				n_requests++;
			end
			if (out_valid && !out_stall) begin
				n_results++;
				if (exact_hit) begin
					n_exact++;
				end
			end
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet++;
		end
	end

	// One request beat. Called on a falling edge, returns on the falling edge
	// after acceptance with valid still high; back-to-back beats drop valid in
	// between only for the random idle gaps taken while idle_on is set.
	task automatic send_format(
		input logic [BITS_W-1:0] bits,
		input logic [RATE_W-1:0] rate,
		input logic              stereo
	);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		sample_bits <= bits;
		sample_rate <= rate;
		is_stereo   <= stereo;
		@(posedge clk);
		while (!(in_valid && !in_stall)) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, let every outstanding result drain, then load a new source
	// clock. Each request yields a result, so an empty queue means idle.
	task automatic retune_source(input logic [SRC_W-1:0] hz);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= hz;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	// Picks a shallow candidate (pre 0 or 1, mostly small main divider),
	// computes its bit clock, and looks for a width class and channel count
	// whose multiplier divides it with a rate that fits. That format ends the
	// walk early. Rarely, or when nothing fits, a fully random format goes out.
	task automatic send_reachable_format(input logic [SRC_W-1:0] hz);
		logic [BITS_W-1:0] bits;
		logic [RATE_W-1:0] rate;
		logic              st;
		longint unsigned   clk_hz, factor;
		int                pre_i, div_i, bd_i, start, cls, tries, k;
		width_class_t      wcls;
		bit                ready;
		ready = 1'b0;
		if (noise_left > 0 && $urandom_range(0, 24) == 0) begin
			noise_left--;
			bits  = $urandom_range(0, 63);
			rate  = $urandom_range(0, (1 << RATE_W) - 1);
			st    = $urandom_range(0, 1);
			ready = 1'b1;
		end
		for (tries = 0; tries < 256 && !ready; tries++) begin
			pre_i  = ($urandom_range(0, 7) == 0) ? 1 : 0;
			div_i  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAIN_MAX)
				: $urandom_range(0, 15);
			bd_i   = $urandom_range(1, BIT_MAX);
			clk_hz = 64'(hz) / 64'(div_i + 1) / 64'(pre_i + 1) / 2 / 64'(bd_i);
			start  = $urandom_range(0, 7);
			for (k = 0; k < 8 && !ready; k++) begin
				cls    = (start + k) % 8;
				wcls   = width_class_t'(cls >> 1);
				st     = cls[0];
				factor = (wcls == OVER_32) ? 64'd1 : (64'd16 << int'(wcls));
				if (st) begin
					factor = factor * 2;
				end
				if (clk_hz % factor == 0 && clk_hz / factor < (1 << RATE_W)) begin
					rate  = RATE_W'(clk_hz / factor);
					ready = 1'b1;
					case (wcls)
						UP_TO_8:  bits = $urandom_range(0, 8);
						UP_TO_16: bits = $urandom_range(9, 16);
						UP_TO_32: bits = $urandom_range(17, 32);
						default:  bits = $urandom_range(33, 63);
					endcase
				end
			end
		end
		if (!ready) begin
			bits = $urandom_range(0, 63);
			rate = $urandom_range(0, (1 << RATE_W) - 1);
			st   = $urandom_range(0, 1);
		end
		send_format(bits, rate, st);
	endtask

	task automatic run_setting(input logic [SRC_W-1:0] hz, input int beats);
		retune_source(hz);
		repeat (beats) send_reachable_format(hz);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset source clock: a typical 48 kHz stereo 16-bit format (nearest
		// candidate search), and a zero target that nothing can beat.
		send_format(6'd16, 19'd48000, 1'b1);
		send_format(6'd24, 19'd0, 1'b0);

		// Source clock zero: zero targets hit at once (width 0 included);
		// the all-ones format has no candidate below its target.
		retune_source('0);
		send_format(6'd0, 19'd0, 1'b1);
		send_format(6'd8, 19'd0, 1'b0);
		send_format(6'd63, 19'h7FFFF, 1'b1);

		// Half the source clock equals the top rate: width above 32 bits,
		// no multiplier, hit on the first candidate.
		retune_source(30'd1048574);
		send_format(6'd33, 19'h7FFFF, 1'b0);

		// Tiny source clock: rate 1, small targets, zero targets reached by
		// deeper dividers.
		retune_source(30'd32);
		send_format(6'd1, 19'd1, 1'b0);
		send_format(6'd40, 19'd4, 1'b1);
		send_format(6'd63, 19'd1, 1'b0);
		send_format(6'd20, 19'd0, 1'b1);
		send_format(6'd32, 19'd0, 1'b0);

		// Power-of-two source clock: every width class boundary lands exactly.
		retune_source(30'd536870912);
		send_format(6'd0, 19'd262144, 1'b0);
		send_format(6'd8, 19'd262144, 1'b1);
		send_format(6'd9, 19'd262144, 1'b1);
		send_format(6'd16, 19'd262144, 1'b1);
		send_format(6'd17, 19'd262144, 1'b1);
		send_format(6'd32, 19'd262144, 1'b1);

		// Random part, one source clock per phase, extremes among them.
		run_setting(SRC_CLK_RESET, 18);
		run_setting(30'h3FFFFFFF, 14);
		run_setting(30'd536870912, 14);
		run_setting(30'($urandom_range(2, 2000000)), 14);
		run_setting(30'd32, 8);
		// Last phase runs flat out on both sides.
		idle_on = 1'b0;
		run_setting(30'($urandom_range(0, 30'h3FFFFFFF)), 20);

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);

		$display("Run covered %0d request beats and %0d result beats over %0d source clocks.",
			n_requests, n_results, n_settings);
		$display("%0d results were exact hits, %0d settled for the nearest clock; %0d mismatches.",
			n_exact, n_results - n_exact, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
